@@ src/mt64_pkg.sv @@
// Package for the 64-bit Mersenne Twister: constants, types and the tempering function.
`timescale 1ns / 1ps
`default_nettype none

package mt64_pkg;

	// Store geometry.
	localparam int unsigned STATE_DEPTH   = 312;
	localparam int unsigned MIDDLE_OFFSET = 156;
	localparam int unsigned IDX_W         = $clog2(STATE_DEPTH + 2);
	localparam int unsigned WORD_W        = 64;

	localparam logic [IDX_W-1:0] IDX_DEPTH    = IDX_W'(STATE_DEPTH);
	localparam logic [IDX_W-1:0] IDX_LAST     = IDX_W'(STATE_DEPTH - 1);
	localparam logic [IDX_W-1:0] IDX_MID      = IDX_W'(MIDDLE_OFFSET);
	localparam logic [IDX_W-1:0] IDX_UNSEEDED = IDX_W'(STATE_DEPTH + 1);
	localparam logic [IDX_W-1:0] IDX_ONE      = IDX_W'(1);

	// Twist constants.
	localparam logic [WORD_W-1:0] TWIST_MATRIX = 64'hB502_6F5A_A966_19E9;
	localparam logic [WORD_W-1:0] UPPER_MASK   = 64'hFFFF_FFFF_8000_0000;
	localparam logic [WORD_W-1:0] LOWER_MASK   = 64'h0000_0000_7FFF_FFFF;

	// Seeding multiplier, split into 32-bit halves for the shared 32x32 multiplier.
	localparam logic [WORD_W-1:0] SEED_MULT    = 64'd6364136223846793005;
	localparam logic [31:0]       SEED_MULT_LO = SEED_MULT[31:0];
	localparam logic [31:0]       SEED_MULT_HI = SEED_MULT[63:32];

	// Tempering masks.
	localparam logic [WORD_W-1:0] TEMPER_D = 64'h5555_5555_5555_5555;
	localparam logic [WORD_W-1:0] TEMPER_B = 64'h71D6_7FFF_EDA6_0000;
	localparam logic [WORD_W-1:0] TEMPER_C = 64'hFFF7_EEE0_0000_0000;

	// Command codes.
	localparam logic CMD_SEED = 1'b0;
	localparam logic CMD_DRAW = 1'b1;

	// Controller states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEED,
		ST_DRAW
	} state_t;

	// Partial products of one seeding multiply.
	typedef enum logic [1:0] {
		PH_LOLO,
		PH_LOHI,
		PH_HILO
	} seed_phase_t;

	// Tempering transform applied to a freshly twisted word.
	function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] v);
		logic [WORD_W-1:0] t;
		t = v;
		t = t ^ ((t >> 29) & TEMPER_D);
		t = t ^ ((t << 17) & TEMPER_B);
		t = t ^ ((t << 37) & TEMPER_C);
		t = t ^ (t >> 43);
		return t;
	endfunction

endpackage

`default_nettype wire

@@ src/mt64_ram.sv @@
// Generic single-write, single-read synchronous RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module mt64_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 312,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; the data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ src/mersenne_twister_64_top.sv @@
// Top level of the 64-bit Mersenne Twister generator with a memory-resident state store.
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+---------------------------
//  req     | in        | req_valid, req_stall | cmd, seed_value
//  rsp     | out       | rsp_valid, rsp_stall | random_word
//
// A draw reads the next and middle words from the two mirrored RAMs when it is accepted,
// then twists, writes back and loads the output register. A reseed writes the seed word,
// then builds each further word from the three partial products of the shared 32x32 multiplier.
// Reset needs no clearing pass: until the first reseed, draws return zero.
// A draw whose result cannot leave the output register waits in its twist cycle.
`timescale 1ns / 1ps
`default_nettype none

module mersenne_twister_64_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        req_valid,
	output logic             req_stall,
	input  wire logic        cmd,
	input  wire logic [63:0] seed_value,
	output logic             rsp_valid,
	input  wire logic        rsp_stall,
	output logic      [63:0] random_word
);

	import mt64_pkg::*;

	state_t state_q, state_d;
	seed_phase_t phase_q;

	logic              seeded_q;
	logic [IDX_W-1:0]  idx_q;
	logic [IDX_W-1:0]  cnt_q;
	logic [WORD_W-1:0] cur_q;
	logic [WORD_W-1:0] prev_q;
	logic [WORD_W-1:0] acc_q;
	logic [WORD_W-1:0] out_word_q;
	logic              out_valid_q;

	logic              req_acc;
	logic              rsp_acc;
	logic              slot_free;
	logic              commit;
	logic [IDX_W-1:0]  idx_eff;
	logic [IDX_W-1:0]  nxt_addr;
	logic [IDX_W-1:0]  mid_addr;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic              ram_re;
	logic [WORD_W-1:0] rd_nxt;
	logic [WORD_W-1:0] rd_mid;

	logic [WORD_W-1:0] twist_y;
	logic [WORD_W-1:0] twist_v;

	logic [WORD_W-1:0] seed_x;
	logic [31:0]       mul_a;
	logic [31:0]       mul_b;
	logic [WORD_W-1:0] seed_prod;
	logic [WORD_W-1:0] seed_word;

	// Handshakes.
	assign req_acc   = req_valid && !req_stall;
	assign rsp_acc   = out_valid_q && !rsp_stall;
	assign slot_free = !out_valid_q || !rsp_stall;
	assign rsp_valid   = out_valid_q;
	assign random_word = out_word_q;

	// Read addresses of a draw: a spent index restarts the round at word zero.
	always_comb begin
		idx_eff  = (idx_q >= IDX_DEPTH) ? '0 : idx_q;
		nxt_addr = (idx_eff == IDX_LAST) ? '0 : idx_eff + IDX_ONE;
		mid_addr = (idx_eff < IDX_MID) ? idx_eff + IDX_MID : idx_eff - IDX_MID;
	end

	// Twist of one word; cur_q always mirrors the store entry at the index.
	always_comb begin
		twist_y = (cur_q & UPPER_MASK) | (rd_nxt & LOWER_MASK);
		twist_v = rd_mid ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_MATRIX : '0);
	end

	// Seeding recurrence, one 32x32 partial product per cycle.
	always_comb begin
		seed_x = prev_q ^ (prev_q >> 62);
		case (phase_q)
			PH_LOLO: begin
				mul_a = seed_x[31:0];
				mul_b = SEED_MULT_LO;
			end
			PH_LOHI: begin
				mul_a = seed_x[31:0];
				mul_b = SEED_MULT_HI;
			end
			default: begin
				mul_a = seed_x[63:32];
				mul_b = SEED_MULT_LO;
			end
		endcase
		seed_prod = WORD_W'(mul_a) * WORD_W'(mul_b);
		seed_word = acc_q + {seed_prod[31:0], 32'b0};
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					state_d = (cmd == CMD_SEED) ? ST_SEED : ST_DRAW;
				end
			end
			ST_SEED: begin
				if (phase_q == PH_HILO && cnt_q == IDX_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_DRAW: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Controller outputs: input stall, RAM ports and the draw commit.
	always_comb begin
		req_stall = 1'b1;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = seed_value;
		ram_re    = 1'b0;
		commit    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				ram_re    = req_acc && (cmd == CMD_DRAW);
				ram_we    = req_acc && (cmd == CMD_SEED);
			end
			ST_SEED: begin
				ram_we    = (phase_q == PH_HILO);
				ram_waddr = cnt_q;
				ram_wdata = seed_word;
			end
			ST_DRAW: begin
				commit    = slot_free;
				ram_we    = slot_free && seeded_q;
				ram_waddr = idx_q;
				ram_wdata = twist_v;
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_LOLO;
			seeded_q    <= 1'b0;
			idx_q       <= IDX_UNSEEDED;
			cnt_q       <= IDX_ONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && req_acc) begin
				if (cmd == CMD_SEED) begin
					seeded_q <= 1'b1;
					idx_q    <= IDX_DEPTH;
					cnt_q    <= IDX_ONE;
					phase_q  <= PH_LOLO;
				end else begin
					idx_q <= idx_eff;
				end
			end
			if (state_q == ST_SEED) begin
				unique case (phase_q)
					PH_LOLO: phase_q <= PH_LOHI;
					PH_LOHI: phase_q <= PH_HILO;
					default: begin
						phase_q <= PH_LOLO;
						cnt_q   <= cnt_q + IDX_ONE;
					end
				endcase
			end
			if (commit) begin
				idx_q <= idx_q + IDX_ONE;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_acc && cmd == CMD_SEED) begin
			prev_q <= seed_value;
			cur_q  <= seed_value;
		end
		if (state_q == ST_SEED) begin
			case (phase_q)
				PH_LOLO: acc_q <= seed_prod + WORD_W'(cnt_q);
				PH_LOHI: acc_q <= seed_word;
				default: prev_q <= seed_word;
			endcase
		end
		if (commit) begin
			cur_q      <= rd_nxt;
			out_word_q <= seeded_q ? temper(twist_v) : '0;
		end
	end

	// Two mirrored copies of the store give two reads per cycle.
	mt64_ram #(
		.WIDTH(64),
		.DEPTH(312)
	) u_ram_nxt (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(nxt_addr),
		.rdata(rd_nxt)
	);

	mt64_ram #(
		.WIDTH(64),
		.DEPTH(312)
	) u_ram_mid (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(mid_addr),
		.rdata(rd_mid)
	);

	// A reseed transaction always starts the seeding sequence.
	a_seed_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && req_acc && cmd == CMD_SEED) |=> (state_q == ST_SEED))
		else $error("reseed did not enter the seeding sequence");

	// Once seeded, the index never runs past the end of the store.
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		seeded_q |-> (idx_q <= IDX_DEPTH))
		else $error("word index out of range after seeding");

	// A new result appears only from the twist cycle of a draw.
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DRAW))
		else $error("result raised outside a draw");

	// The seeding counter stays within the words that follow the seed word.
	a_seed_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEED) |-> (cnt_q >= IDX_ONE && cnt_q <= IDX_LAST))
		else $error("seeding counter out of range");

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for the 64-bit Mersenne Twister top level.
`timescale 1ns / 1ps

module tb_top;

	import mt64_pkg::*;

	// Generator constants for the checker's own copy of the algorithm.
	localparam logic [63:0] MT_MATRIX  = 64'hB502_6F5A_A966_19E9;
	localparam logic [63:0] MT_HI_MASK = 64'hFFFF_FFFF_8000_0000;
	localparam logic [63:0] MT_LO_MASK = 64'h0000_0000_7FFF_FFFF;
	localparam logic [63:0] MT_MULT    = 64'd6364136223846793005;
	localparam logic [63:0] MT_TMASK_D = 64'h5555_5555_5555_5555;
	localparam logic [63:0] MT_TMASK_B = 64'h71D6_7FFF_EDA6_0000;
	localparam logic [63:0] MT_TMASK_C = 64'hFFF7_EEE0_0000_0000;

	// A reseed occupies the block through its whole seeding sequence; the drain wait covers it.
	localparam int DRAIN_CYCLES = 1000;
	localparam int RANDOM_ITEMS = 1700;
	localparam int N_DIRECTED   = 25;
	localparam int MAX_REPORTS  = 50;

	// One row of the directed table: command, seed, and an optional fixed result.
	typedef struct packed {
		logic        op;
		logic [63:0] seed;
		logic        pinned;
		logic [63:0] word;
	} stim_row_t;

	// The first three rows draw before any seed and must return zero, whatever the seed field carries.
	localparam stim_row_t DIRECTED [N_DIRECTED] = '{
		'{CMD_DRAW, 64'h0000_0000_0000_0000, 1'b1, 64'h0},
		'{CMD_DRAW, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 64'h0},
		'{CMD_DRAW, 64'h0000_0000_0000_1571, 1'b1, 64'h0},
		'{CMD_SEED, 64'h0000_0000_0000_0000, 1'b0, 64'h0},
		'{CMD_DRAW, 64'h0000_0000_0000_0000, 1'b0, 64'h0},
		'{CMD_DRAW, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
		'{CMD_SEED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 64'h0},
		'{CMD_DRAW, 64'h0000_0000_0000_0000, 1'b0, 64'h0},
		'{CMD_DRAW, 64'h0000_0000_0000_0000, 1'b0, 64'h0},
		'{CMD_SEED, 64'h0000_0000_0000_0001, 1'b0, 64'h0},
		'{CMD_SEED, 64'h8000_0000_0000_0000, 1'b0, 64'h0},
		'{CMD_DRAW, 64'h0000_0000_0000_0000, 1'b0, 64'h0},
		'{CMD_SEED, 64'h0000_0000_0000_1571, 1'b0, 64'h0},
		'{CMD_DRAW, 64'h0000_0000_0000_0000, 1'b0, 64'h0},
		'{CMD_DRAW, 64'h0000_0000_0000_0000, 1'b0, 64'h0},
		'{CMD_DRAW, 64'h0000_0000_0000_0000, 1'b0, 64'h0},
		'{CMD_SEED, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 64'h0},
		'{CMD_DRAW, 64'h5555_5555_5555_5555, 1'b0, 64'h0},
		'{CMD_SEED, 64'h5555_5555_5555_5555, 1'b0, 64'h0},
		'{CMD_SEED, 64'h0123_4567_89AB_CDEF, 1'b0, 64'h0},
		'{CMD_DRAW, 64'h0000_0000_0000_0000, 1'b0, 64'h0},
		'{CMD_DRAW, 64'h0000_0000_0000_0000, 1'b0, 64'h0},
		'{CMD_SEED, 64'hFFFF_FFFF_0000_0000, 1'b0, 64'h0},
		'{CMD_DRAW, 64'h0000_0000_0000_0000, 1'b0, 64'h0},
		'{CMD_DRAW, 64'h0000_0000_0000_0000, 1'b0, 64'h0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic        cmd = CMD_SEED;
	logic [63:0] seed_value = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [63:0] random_word;

	// Fixed result travelling alongside a directed transaction.
	logic        pin_check = 1'b0;
	logic [63:0] pin_word = '0;

	// Checker's copy of the generator state.
	logic [63:0] mt_store [STATE_DEPTH];
	logic [8:0]  mt_pos;
	logic [63:0] pending_words [$];
	logic [63:0] predicted;
	logic [63:0] wanted;
	int          mismatch_count = 0;
	bit          req_burst = 1'b0;

	mersenne_twister_64_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.cmd         (cmd),
		.seed_value  (seed_value),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.random_word (random_word)
	);

	always #1 clk = ~clk;

	// Fill the store from a seed with the multiplicative recurrence.
	function automatic void mt_seed(input logic [63:0] s);
		int i;
		mt_store[0] = s;
		for (i = 1; i < STATE_DEPTH; i++) begin
			mt_store[i] = MT_MULT * (mt_store[i-1] ^ (mt_store[i-1] >> 62)) + 64'(i);
		end
		mt_pos = 9'(STATE_DEPTH);
	endfunction

	// Regenerate the whole store in place; later words see earlier updated ones.
	function automatic void mt_twist();
		int          i;
		logic [63:0] y;
		logic [63:0] v;
		for (i = 0; i < STATE_DEPTH; i++) begin
			y = (mt_store[i] & MT_HI_MASK) | (mt_store[(i + 1) % STATE_DEPTH] & MT_LO_MASK);
			v = mt_store[(i + MIDDLE_OFFSET) % STATE_DEPTH] ^ (y >> 1);
			if (y[0]) begin
				v = v ^ MT_MATRIX;
			end
			mt_store[i] = v;
		end
	endfunction

	function automatic logic [63:0] mt_temper(input logic [63:0] v);
		logic [63:0] t;
		t = v ^ ((v >> 29) & MT_TMASK_D);
		t = t ^ ((t << 17) & MT_TMASK_B);
		t = t ^ ((t << 37) & MT_TMASK_C);
		t = t ^ (t >> 43);
		return t;
	endfunction

	// Next output word; an exhausted or unseeded store is twisted first.
	function automatic logic [63:0] mt_next_word();
		logic [63:0] w;
		if (mt_pos >= STATE_DEPTH) begin
			mt_twist();
			mt_pos = '0;
		end
		w = mt_temper(mt_store[mt_pos]);
		mt_pos = mt_pos + 9'd1;
		return w;
	endfunction

	// Idle run length: mostly short, now and then long.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	// Present one request transaction and hold it until it is accepted.
	task automatic offer(input logic op, input logic [63:0] sv, input logic pinned,
		input logic [63:0] word);
		int gap;
		gap = req_burst ? 0 : idle_len();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid  <= 1'b1;
		cmd        <= op;
		seed_value <= sv;
		pin_check  <= pinned;
		pin_word   <= word;
		do @(posedge clk); while (req_stall);
	endtask

	// Predict on accepted requests and check accepted responses.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mt_store = '{default: '0};
			mt_pos = 9'(STATE_DEPTH + 1);
			pending_words.delete();
		end else begin
			if (req_valid && !req_stall) begin
				if (cmd == CMD_SEED) begin
					mt_seed(seed_value);
				end else begin
					predicted = mt_next_word();
					pending_words.push_back(pin_check ? pin_word : predicted);
				end
			end
			if (rsp_valid && !rsp_stall) begin
				if (pending_words.size() == 0) begin
					if (mismatch_count < MAX_REPORTS) begin
						$display("%0t: unexpected word, expected none, actual %h",
							$realtime, random_word);
					end
					mismatch_count++;
				end else begin
					wanted = pending_words.pop_front();
					if (random_word !== wanted) begin
						if (mismatch_count < MAX_REPORTS) begin
							$display("%0t: random_word mismatch, expected %h, actual %h",
								$realtime, wanted, random_word);
						end
						mismatch_count++;
					end
				end
			end
		end
	end

	// Response back-pressure in runs of random length.
	initial begin : stall_gen
		int len;
		@(posedge clk);
		forever begin
			len = idle_len() + 1;
			rsp_stall <= ($urandom_range(0, 4) < 2);
			repeat (len) @(posedge clk);
		end
	end

	// Reset, directed table, random sequences, drain and verdict.
	initial begin : stimulus
		int          row;
		int          sent;
		int          seg;
		int          draws;
		int          r;
		logic [63:0] s;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (row = 0; row < N_DIRECTED; row++) begin
			offer(DIRECTED[row].op, DIRECTED[row].seed, DIRECTED[row].pinned,
				DIRECTED[row].word);
		end

		// Mostly a reseed followed by a run of draws; some runs cross the twist.
		sent = 0;
		seg = 0;
		while (sent < RANDOM_ITEMS) begin
			req_burst = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (seg == 0 || r < 15) begin
				draws = $urandom_range(300, 650);
			end else if (r < 75) begin
				draws = $urandom_range(1, 60);
			end else if (r < 85) begin
				draws = $urandom_range(0, 20);
				offer(CMD_SEED, {$urandom(), $urandom()}, 1'b0, '0);
				sent++;
			end else begin
				draws = $urandom_range(1, 100);
			end
			if (seg == 0 || r < 85) begin
				case ($urandom_range(0, 9))
					0: s = '0;
					1: s = '1;
					default: s = {$urandom(), $urandom()};
				endcase
				offer(CMD_SEED, s, 1'b0, '0);
				sent++;
			end
			// The last run is cut short so the total stays near the item budget.
			while (draws > 0 && sent < RANDOM_ITEMS) begin
				offer(CMD_DRAW, {$urandom(), $urandom()}, 1'b0, '0);
				sent++;
				draws--;
			end
			seg++;
		end
		req_valid <= 1'b0;

		while (pending_words.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_words.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

	// Guard against a hung handshake.
	initial begin : watchdog
		#2_000_000;
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
